// File: rtl/recursive_mutex_priority_inherit_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the recursive mutex core
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef RECURSIVE_MUTEX_PRIORITY_INHERIT_CORE_DEFINES_SVH
`define RECURSIVE_MUTEX_PRIORITY_INHERIT_CORE_DEFINES_SVH

// An invariant that must hold at every edge outside of reset.
`define RMPI_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// A condition that implies another one at the same edge.
`define RMPI_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/rmpi_pkg.sv
// ----------------------------------------------------------------------------
// Recursive mutex package
// Widths, request and status codes, and the waiter entry type.
// ----------------------------------------------------------------------------
package rmpi_pkg;

	localparam int MAX_TASKS       = 16;
	localparam int PRIORITY_LEVELS = 32;
	localparam int MAX_WAITERS     = 16;
	localparam int MAX_NESTING     = 255;

	localparam int MODE_W   = 3;
	localparam int ID_W     = 4;
	localparam int PRIO_W   = 5;
	localparam int STATUS_W = 4;
	localparam int NEST_W   = 8;

	// The nesting count saturates at its own width as well.
	localparam int NEST_CAP = (MAX_NESTING < 255) ? MAX_NESTING : 255;
	localparam int WCNT_W   = $clog2(MAX_WAITERS + 1);
	localparam int WIDX_W   = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;

	localparam logic [MODE_W-1:0] MODE_LOCK   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TRY    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_UNLOCK = 3'd2;
	localparam logic [MODE_W-1:0] MODE_CANCEL = 3'd3;

	localparam logic [STATUS_W-1:0] STS_ACQUIRED    = 4'd0;
	localparam logic [STATUS_W-1:0] STS_NESTED      = 4'd1;
	localparam logic [STATUS_W-1:0] STS_QUEUED      = 4'd2;
	localparam logic [STATUS_W-1:0] STS_BUSY        = 4'd3;
	localparam logic [STATUS_W-1:0] STS_STILL_HELD  = 4'd4;
	localparam logic [STATUS_W-1:0] STS_FREED       = 4'd5;
	localparam logic [STATUS_W-1:0] STS_HANDED      = 4'd6;
	localparam logic [STATUS_W-1:0] STS_NOT_OWNER   = 4'd7;
	localparam logic [STATUS_W-1:0] STS_QUEUE_FULL  = 4'd8;
	localparam logic [STATUS_W-1:0] STS_CANCELLED   = 4'd9;
	localparam logic [STATUS_W-1:0] STS_NOT_WAITING = 4'd10;
	localparam logic [STATUS_W-1:0] STS_NEST_OVF    = 4'd11;
	localparam logic [STATUS_W-1:0] STS_QUERY       = 4'd12;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} waiter_t;

	// Search token handed from one queue cell to the next.
	typedef struct packed {
		logic tok;
		logic seen;
	} link_t;

	// Broadcast control from the sequencer to every queue cell.
	typedef struct packed {
		logic              remove;
		logic [ID_W-1:0]   key;
		logic              wr_en;
		waiter_t           wr_data;
		logic [WCNT_W-1:0] count;
	} cell_ctl_t;

	function automatic logic [PRIO_W-1:0] sat_prio(input logic [PRIO_W-1:0] p);
		logic [PRIO_W:0] top;
		top = (PRIO_W+1)'(PRIORITY_LEVELS - 1);
		sat_prio = ({1'b0, p} > top) ? top[PRIO_W-1:0] : p;
	endfunction

endpackage

// File: rtl/rmpi_ifs.sv
// ----------------------------------------------------------------------------
// Recursive mutex channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rmpi_req_if;
	import rmpi_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ID_W-1:0]   task_id;
	logic [PRIO_W-1:0] task_priority;

	modport source (output valid, output mode, output task_id, output task_priority,
		input ready);
	modport sink (input valid, input mode, input task_id, input task_priority,
		output ready);
endinterface

interface rmpi_rsp_if;
	import rmpi_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                owner_valid;
	logic [ID_W-1:0]     owner_task;
	logic                is_owner;
	logic                prio_change_valid;
	logic [ID_W-1:0]     prio_change_task;
	logic [PRIO_W-1:0]   prio_change_value;
	logic                woken_valid;
	logic [ID_W-1:0]     woken_task;
	logic                preempt_request;
	logic [NEST_W-1:0]   hold_count;

	modport source (output valid, output status, output owner_valid, output owner_task,
		output is_owner, output prio_change_valid, output prio_change_task,
		output prio_change_value, output woken_valid, output woken_task,
		output preempt_request, output hold_count, input ready);
	modport sink (input valid, input status, input owner_valid, input owner_task,
		input is_owner, input prio_change_valid, input prio_change_task,
		input prio_change_value, input woken_valid, input woken_task,
		input preempt_request, input hold_count, output ready);
endinterface

// File: rtl/rmpi_cell.sv
// ----------------------------------------------------------------------------
// Waiter queue cell
// Holds one queue slot, compares it when the search token passes, and pulls
// the neighbor's entry when an entry at or before it is removed.
// ----------------------------------------------------------------------------
module rmpi_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [rmpi_pkg::WIDX_W-1:0] cell_idx,
	input  rmpi_pkg::cell_ctl_t      ctl,
	input  rmpi_pkg::link_t          link_in,
	input  rmpi_pkg::waiter_t        next_data,
	output rmpi_pkg::link_t          link_out,
	output rmpi_pkg::waiter_t        data
);
	import rmpi_pkg::*;

	waiter_t           data_q;
	link_t             link_q;
	logic              live;
	logic              hit;
	logic [WCNT_W-1:0] my_pos;

	assign my_pos = WCNT_W'(cell_idx);
	assign live   = my_pos < ctl.count;
	// The first match, or any match further up the row, shifts this slot.
	assign hit    = link_in.seen | (live && (data_q.id == ctl.key));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else begin
			link_q.tok  <= link_in.tok;
			link_q.seen <= link_in.tok & hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && (my_pos == ctl.count)) begin
			data_q <= ctl.wr_data;
		end else if (link_in.tok && ctl.remove && hit) begin
			data_q <= next_data;
		end
	end

	assign link_out = link_q;
	assign data     = data_q;
endmodule

// File: rtl/recursive_mutex_priority_inherit_core.sv
// ----------------------------------------------------------------------------
// Recursive mutex with priority inheritance
// One hardware lock with owner tracking, nesting, a FIFO of waiters and
// priority boosting of the owner.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req channel (mode, task id, priority) and each one
// produces exactly one beat on the rsp channel, carrying the status, the lock
// state after the request and any priority change, wake-up or preemption.
// Requests that need no look at the waiter queue (lock of a free lock,
// nesting, try refusal, partial unlock, full release with no waiters, query,
// unlock by a non-owner) go straight from the execute state to the finishing
// state. Blocking locks by another task, cancels and full releases that hand
// the lock over walk a search token down the row of queue cells, one cell per
// cycle, before they finish. A new request is taken once the previous one has
// been written to the response register; if the receiver stalls, that
// register holds the beat while the next request is processed, and the next
// result waits until the register is free. Reset clears the owner, the
// nesting count and the waiter count; queue slots need no clearing since only
// slots below the waiter count are ever looked at.
// ----------------------------------------------------------------------------
`include "recursive_mutex_priority_inherit_core_defines.svh"

module recursive_mutex_priority_inherit_core (
	input  logic        clk,
	input  logic        arst_n,
	rmpi_req_if.sink    req,
	rmpi_rsp_if.source  rsp
);
	import rmpi_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FIN
	} state_t;

	state_t state_q;

	// Request held for the whole operation.
	logic [MODE_W-1:0] req_mode_q;
	logic [ID_W-1:0]   req_id_q;
	logic [PRIO_W-1:0] req_prio_q;

	// Lock state.
	logic              owner_vld_q;
	logic [ID_W-1:0]   owner_id_q;
	logic [PRIO_W-1:0] base_q;
	logic [PRIO_W-1:0] eff_q;
	logic [NEST_W-1:0] nest_q;
	logic [WCNT_W-1:0] wcnt_q;

	// Result fields gathered before the response register is loaded.
	logic [STATUS_W-1:0] status_q;
	logic                pcv_q;
	logic [ID_W-1:0]     pct_q;
	logic [PRIO_W-1:0]   pcval_q;
	logic                wv_q;
	logic [ID_W-1:0]     wt_q;
	logic                pre_q;

	// Search and append control for the cell row.
	logic    start_q;
	logic    force_q;
	logic    remove_q;
	logic    wr_en_q;
	waiter_t wr_data_q;

	// Response register.
	logic                out_vld_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_owner_vld_q;
	logic [ID_W-1:0]     out_owner_task_q;
	logic                out_is_owner_q;
	logic                out_pcv_q;
	logic [ID_W-1:0]     out_pct_q;
	logic [PRIO_W-1:0]   out_pcval_q;
	logic                out_wv_q;
	logic [ID_W-1:0]     out_wt_q;
	logic                out_pre_q;
	logic [NEST_W-1:0]   out_hold_q;

	cell_ctl_t ctl;
	link_t     link   [MAX_WAITERS+1];
	waiter_t   cdata  [MAX_WAITERS];
	logic      scan_done;
	logic      scan_found;
	waiter_t   head;
	logic      queue_full;
	logic      boost;

	// The row of queue cells. The search token enters at the head slot and
	// leaves at the tail; during a removal each slot at or after the match
	// pulls the entry of its neighbor as the token passes it.
	assign link[0].tok  = start_q;
	assign link[0].seen = start_q & force_q;

	assign ctl.remove  = remove_q;
	assign ctl.key     = req_id_q;
	assign ctl.wr_en   = wr_en_q;
	assign ctl.wr_data = wr_data_q;
	assign ctl.count   = wcnt_q;

	for (genvar g = 0; g < MAX_WAITERS; g++) begin : g_cell
		waiter_t nb;
		if (g < MAX_WAITERS - 1) begin : g_mid
			assign nb = cdata[g+1];
		end else begin : g_tail
			assign nb = '0;
		end
		rmpi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (WIDX_W'(g)),
			.ctl       (ctl),
			.link_in   (link[g]),
			.next_data (nb),
			.link_out  (link[g+1]),
			.data      (cdata[g])
		);
	end

	assign scan_done  = link[MAX_WAITERS].tok;
	assign scan_found = link[MAX_WAITERS].seen;
	assign head       = cdata[0];
	assign queue_full = wcnt_q >= WCNT_W'(MAX_WAITERS);
	assign boost      = req_prio_q < eff_q;

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			req_mode_q       <= '0;
			req_id_q         <= '0;
			req_prio_q       <= '0;
			owner_vld_q      <= 1'b0;
			owner_id_q       <= '0;
			base_q           <= '0;
			eff_q            <= '0;
			nest_q           <= '0;
			wcnt_q           <= '0;
			status_q         <= STS_QUERY;
			pcv_q            <= 1'b0;
			pct_q            <= '0;
			pcval_q          <= '0;
			wv_q             <= 1'b0;
			wt_q             <= '0;
			pre_q            <= 1'b0;
			start_q          <= 1'b0;
			force_q          <= 1'b0;
			remove_q         <= 1'b0;
			wr_en_q          <= 1'b0;
			wr_data_q        <= '0;
			out_vld_q        <= 1'b0;
			out_status_q     <= STS_QUERY;
			out_owner_vld_q  <= 1'b0;
			out_owner_task_q <= '0;
			out_is_owner_q   <= 1'b0;
			out_pcv_q        <= 1'b0;
			out_pct_q        <= '0;
			out_pcval_q      <= '0;
			out_wv_q         <= 1'b0;
			out_wt_q         <= '0;
			out_pre_q        <= 1'b0;
			out_hold_q       <= '0;
		end else begin
			// The finishing state reloads the response register itself.
			if (out_vld_q && rsp.ready && (state_q != ST_FIN)) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						req_mode_q <= req.mode;
						req_id_q   <= req.task_id;
						req_prio_q <= sat_prio(req.task_priority);
						status_q   <= STS_QUERY;
						pcv_q      <= 1'b0;
						pct_q      <= '0;
						pcval_q    <= '0;
						wv_q       <= 1'b0;
						wt_q       <= '0;
						pre_q      <= 1'b0;
						state_q    <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					case (req_mode_q)
						MODE_LOCK, MODE_TRY: begin
							if (!owner_vld_q) begin
								owner_vld_q <= 1'b1;
								owner_id_q  <= req_id_q;
								base_q      <= req_prio_q;
								eff_q       <= req_prio_q;
								nest_q      <= NEST_W'(1);
								status_q    <= STS_ACQUIRED;
								state_q     <= ST_FIN;
							end else if (owner_id_q == req_id_q) begin
								state_q <= ST_FIN;
								if (nest_q >= NEST_W'(NEST_CAP)) begin
									status_q <= STS_NEST_OVF;
								end else begin
									nest_q   <= nest_q + NEST_W'(1);
									status_q <= STS_NESTED;
								end
							end else if (req_mode_q == MODE_TRY) begin
								status_q <= STS_BUSY;
								state_q  <= ST_FIN;
							end else begin
								// Look for the task in the queue before queuing it.
								start_q  <= 1'b1;
								force_q  <= 1'b0;
								remove_q <= 1'b0;
								state_q  <= ST_SCAN;
							end
						end
						MODE_UNLOCK: begin
							if (!owner_vld_q || (owner_id_q != req_id_q)) begin
								status_q <= STS_NOT_OWNER;
								state_q  <= ST_FIN;
							end else if (nest_q > NEST_W'(1)) begin
								nest_q   <= nest_q - NEST_W'(1);
								status_q <= STS_STILL_HELD;
								state_q  <= ST_FIN;
							end else begin
								// Full release: the releaser returns to its base priority.
								pcv_q   <= 1'b1;
								pct_q   <= owner_id_q;
								pcval_q <= base_q;
								if (wcnt_q != '0) begin
									owner_id_q <= head.id;
									base_q     <= head.prio;
									eff_q      <= head.prio;
									nest_q     <= NEST_W'(1);
									wv_q       <= 1'b1;
									wt_q       <= head.id;
									pre_q      <= head.prio < base_q;
									status_q   <= STS_HANDED;
									// Pop the head slot with a forced match at cell zero.
									start_q    <= 1'b1;
									force_q    <= 1'b1;
									remove_q   <= 1'b1;
									state_q    <= ST_SCAN;
								end else begin
									owner_vld_q <= 1'b0;
									owner_id_q  <= '0;
									base_q      <= '0;
									eff_q       <= '0;
									nest_q      <= '0;
									status_q    <= STS_FREED;
									state_q     <= ST_FIN;
								end
							end
						end
						MODE_CANCEL: begin
							start_q  <= 1'b1;
							force_q  <= 1'b0;
							remove_q <= 1'b1;
							state_q  <= ST_SCAN;
						end
						default: begin
							status_q <= STS_QUERY;
							state_q  <= ST_FIN;
						end
					endcase
				end

				ST_SCAN: begin
					start_q <= 1'b0;
					if (scan_done) begin
						state_q <= ST_FIN;
						case (req_mode_q)
							MODE_LOCK: begin
								if (!scan_found && queue_full) begin
									status_q <= STS_QUEUE_FULL;
								end else begin
									if (!scan_found) begin
										wr_en_q   <= 1'b1;
										wr_data_q <= '{id: req_id_q, prio: req_prio_q};
									end
									if (boost) begin
										eff_q   <= req_prio_q;
										pcv_q   <= 1'b1;
										pct_q   <= owner_id_q;
										pcval_q <= req_prio_q;
									end
									status_q <= STS_QUEUED;
								end
							end
							MODE_CANCEL: begin
								if (scan_found) begin
									wcnt_q   <= wcnt_q - WCNT_W'(1);
									status_q <= STS_CANCELLED;
								end else begin
									status_q <= STS_NOT_WAITING;
								end
							end
							MODE_UNLOCK: begin
								wcnt_q <= wcnt_q - WCNT_W'(1);
							end
							default: begin
								status_q <= STS_QUERY;
							end
						endcase
					end
				end

				ST_FIN: begin
					// The append lands in the cells on this edge, with the old count.
					if (wr_en_q) begin
						wr_en_q <= 1'b0;
						wcnt_q  <= wcnt_q + WCNT_W'(1);
					end
					if (!out_vld_q || rsp.ready) begin
						out_vld_q        <= 1'b1;
						out_status_q     <= status_q;
						out_owner_vld_q  <= owner_vld_q;
						out_owner_task_q <= owner_vld_q ? owner_id_q : '0;
						out_is_owner_q   <= owner_vld_q && (owner_id_q == req_id_q);
						out_pcv_q        <= pcv_q;
						out_pct_q        <= pct_q;
						out_pcval_q      <= pcval_q;
						out_wv_q         <= wv_q;
						out_wt_q         <= wt_q;
						out_pre_q        <= pre_q;
						out_hold_q       <= nest_q;
						state_q          <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid             = out_vld_q;
	assign rsp.status            = out_status_q;
	assign rsp.owner_valid       = out_owner_vld_q;
	assign rsp.owner_task        = out_owner_task_q;
	assign rsp.is_owner          = out_is_owner_q;
	assign rsp.prio_change_valid = out_pcv_q;
	assign rsp.prio_change_task  = out_pct_q;
	assign rsp.prio_change_value = out_pcval_q;
	assign rsp.woken_valid       = out_wv_q;
	assign rsp.woken_task        = out_wt_q;
	assign rsp.preempt_request   = out_pre_q;
	assign rsp.hold_count        = out_hold_q;

	// The waiter count never runs past the number of queue cells.
	`RMPI_ASSERT_ALWAYS(a_wcnt_range, wcnt_q <= WCNT_W'(MAX_WAITERS), "waiter count overflow")
	// A held lock always has a nonzero nesting count, a free one has zero.
	`RMPI_ASSERT_ALWAYS(a_nest_owner, owner_vld_q == (nest_q != '0), "nest count out of step")
	// The search token only leaves the row while the sequencer waits for it.
	`RMPI_ASSERT_IMPLY(a_scan_state, scan_done, state_q == ST_SCAN, "stray search token")
	// An append is only issued into a free slot.
	`RMPI_ASSERT_IMPLY(a_append_room, wr_en_q, wcnt_q < WCNT_W'(MAX_WAITERS), "append to full queue")
endmodule
